/* hw/rtl/skein1024_ubi_block_engine_top_defines.svh */
// Assertion macros used by the block engine's back part.
`ifndef SKEIN1024_UBI_BLOCK_ENGINE_TOP_DEFINES_SVH
`define SKEIN1024_UBI_BLOCK_ENGINE_TOP_DEFINES_SVH
// Implication checked at each clock edge outside reset.
`define SKA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked at each clock edge outside reset.
`define SKA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/sk1024_pkg.sv */
// Shared types, constants and round functions of the Skein-1024 block engine.
package sk1024_pkg;
    typedef logic [63:0] t_word;
    typedef t_word [15:0] t_block;

    localparam t_word PARITY_WORD = 64'h1BD11BDAA9FC1A22;

    // Block request passed from the front part to the back part.
    typedef struct packed {
        t_block msg;
        logic [7:0] byte_count;
        logic new_type;
        logic [5:0] block_type;
        logic final_block;
        logic clear_chain;
        logic emit;
        logic keep_chain;
    } t_blk_req;

    function automatic logic [5:0] rot_amt(input logic [2:0] r, input logic [2:0] j);
        logic [5:0] t [0:63];
        t = '{6'd24,6'd13,6'd8,6'd47,6'd8,6'd17,6'd22,6'd37,
              6'd38,6'd19,6'd10,6'd55,6'd49,6'd18,6'd23,6'd52,
              6'd33,6'd4,6'd51,6'd13,6'd34,6'd41,6'd59,6'd17,
              6'd5,6'd20,6'd48,6'd41,6'd47,6'd28,6'd16,6'd25,
              6'd41,6'd9,6'd37,6'd31,6'd12,6'd47,6'd44,6'd30,
              6'd16,6'd34,6'd56,6'd51,6'd4,6'd53,6'd42,6'd41,
              6'd31,6'd44,6'd47,6'd46,6'd19,6'd42,6'd44,6'd25,
              6'd9,6'd48,6'd35,6'd52,6'd23,6'd31,6'd37,6'd20};
        return t[{r, j}];
    endfunction

    function automatic logic [3:0] word_ord(input logic [1:0] p, input logic [3:0] k);
        logic [3:0] t [0:63];
        t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,
              4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
              4'd0,4'd9,4'd2,4'd13,4'd6,4'd11,4'd4,4'd15,
              4'd10,4'd7,4'd12,4'd3,4'd14,4'd5,4'd8,4'd1,
              4'd0,4'd7,4'd2,4'd5,4'd4,4'd3,4'd6,4'd1,
              4'd12,4'd15,4'd14,4'd13,4'd8,4'd11,4'd10,4'd9,
              4'd0,4'd15,4'd2,4'd11,4'd6,4'd13,4'd4,4'd9,
              4'd14,4'd1,4'd8,4'd5,4'd10,4'd3,4'd12,4'd7};
        return t[{p, k}];
    endfunction

    function automatic t_word rotl(input t_word v, input logic [5:0] n);
        logic [127:0] d;
        d = {v, v} << n;
        return d[127:64];
    endfunction

    // One Threefish-1024 round: eight MIX operations.
    function automatic t_block mix_round(input t_block x, input logic [6:0] r);
        t_block y;
        t_word s;
        logic [3:0] a;
        logic [3:0] b;
        y = x;
        for (int j = 0; j < 8; j++) begin
            a = word_ord(r[1:0], 4'(2 * j));
            b = word_ord(r[1:0], 4'(2 * j + 1));
            s = x[a] + x[b];
            y[a] = s;
            y[b] = rotl(x[b], rot_amt(r[2:0], 3'(j))) ^ s;
        end
        return y;
    endfunction
endpackage

/* hw/rtl/sk1024_front.sv */
// Front part: collects sixteen message words into a block request.
module sk1024_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  sk1024_pkg::t_word      i_data_word,
    input  logic [7:0]             i_byte_count,
    input  logic                   i_new_type,
    input  logic [5:0]             i_block_type,
    input  logic                   i_final_block,
    input  logic                   i_clear_chain,
    input  logic                   i_emit_chain,
    input  logic                   i_keep_chain,
    output logic                   o_req_valid,
    input  logic                   i_req_stall,
    output sk1024_pkg::t_blk_req   o_req
);
    sk1024_pkg::t_block r_buf;
    logic [3:0] r_cnt;
    logic r_full;
    sk1024_pkg::t_blk_req r_req;
    logic acc;

    assign o_stall     = r_full;
    assign acc         = i_valid && !r_full;
    assign o_req_valid = r_full;
    assign o_req       = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_full <= 1'b0;
        end else begin
            if (acc) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) r_full <= 1'b1;
            end else if (r_full && !i_req_stall) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_buf[r_cnt] <= i_data_word;
            if (r_cnt == 4'd15) begin
                r_req.msg         <= {i_data_word, r_buf[14:0]};
                r_req.byte_count  <= i_byte_count;
                r_req.new_type    <= i_new_type;
                r_req.block_type  <= i_block_type;
                r_req.final_block <= i_final_block;
                r_req.clear_chain <= i_clear_chain;
                r_req.emit        <= i_emit_chain | i_keep_chain;
                r_req.keep_chain  <= i_keep_chain;
            end
        end
    end
endmodule

/* hw/rtl/sk1024_back.sv */
// Back part: Threefish-1024 rounds, UBI chaining and word output.
`include "skein1024_ubi_block_engine_top_defines.svh"
module sk1024_back #(
    parameter int ROUNDS = 80
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    output logic                   o_req_stall,
    input  sk1024_pkg::t_blk_req   i_req,
    output logic                   o_valid,
    input  logic                   i_stall,
    output sk1024_pkg::t_word      o_chain_word,
    output logic                   o_last_out
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_RUN = 4'b0010, S_INJ = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_state r_state;
    sk1024_pkg::t_block r_chain, r_old, r_key, r_x, r_msg;
    sk1024_pkg::t_word r_tpos, r_tflg, r_kpar;
    logic [6:0] r_rnd;
    logic [4:0] r_sub;
    logic [3:0] r_oidx;
    logic r_keep;
    logic r_emit;
    sk1024_pkg::t_block mixed, injected;
    sk1024_pkg::t_word tw [0:2];
    sk1024_pkg::t_word n_tpos, n_tflg, kp;
    logic [4:0] ki;
    logic [5:0] kis;
    logic [4:0] sub_m3;
    logic [1:0] t0, t1;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_chain_word = r_chain[r_oidx];
    assign o_last_out   = (r_oidx == 4'd15);

    assign mixed = sk1024_pkg::mix_round(r_x, r_rnd);
    assign tw[0] = r_tpos;
    assign tw[1] = r_tflg;
    assign tw[2] = r_tpos ^ r_tflg;

    always_comb begin
        sub_m3 = r_sub;
        for (int k = 0; k < 6; k++) if (sub_m3 >= 5'd3) sub_m3 = sub_m3 - 5'd3;
        t0 = sub_m3[1:0];
        t1 = (t0 == 2'd2) ? 2'd0 : t0 + 2'd1;
        injected = r_x;
        for (int i = 0; i < 16; i++) begin
            kis = 6'(r_sub) + 6'(i);
            if (kis >= 6'd34) kis = kis - 6'd34;
            else if (kis >= 6'd17) kis = kis - 6'd17;
            ki = kis[4:0];
            kp = (ki == 5'd16) ? r_kpar : r_key[ki[3:0]];
            injected[i] = r_x[i] + kp;
        end
        injected[13] = injected[13] + tw[t0];
        injected[14] = injected[14] + tw[t1];
        injected[15] = injected[15] + 64'(r_sub);
    end

    always_comb begin
        n_tpos = i_req.new_type ? '0 : r_tpos;
        n_tflg = i_req.new_type ? {2'b01, i_req.block_type, 56'd0} : r_tflg;
        if (i_req.final_block) n_tflg[63] = 1'b1;
        n_tpos = n_tpos + 64'(i_req.byte_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chain <= '0;
            r_tpos  <= '0;
            r_tflg  <= '0;
            r_oidx  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_req_valid) begin
                    r_tpos  <= n_tpos;
                    r_tflg  <= n_tflg;
                    r_old   <= r_chain;
                    r_key   <= i_req.clear_chain ? '0 : r_chain;
                    r_kpar  <= sk1024_pkg::PARITY_WORD ^ (i_req.clear_chain ? 64'd0 :
                        (r_chain[0]^r_chain[1]^r_chain[2]^r_chain[3]^r_chain[4]^
                         r_chain[5]^r_chain[6]^r_chain[7]^r_chain[8]^r_chain[9]^
                         r_chain[10]^r_chain[11]^r_chain[12]^r_chain[13]^
                         r_chain[14]^r_chain[15]));
                    r_x     <= i_req.msg;
                    r_msg   <= i_req.msg;
                    r_keep  <= i_req.keep_chain;
                    r_rnd   <= '0;
                    r_sub   <= '0;
                    r_oidx  <= '0;
                    r_state <= S_INJ;
                    r_emit  <= i_req.emit;
                end
                S_INJ: begin
                    r_x   <= injected;
                    r_sub <= r_sub + 5'd1;
                    if (r_rnd == 7'(ROUNDS)) begin
                        for (int i = 0; i < 16; i++) r_chain[i] <= injected[i] ^ r_msg[i];
                        r_state <= r_emit ? S_OUT : S_IDLE;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_x   <= mixed;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'(ROUNDS - 1)) begin
                        if (ROUNDS % 4 == 0) r_state <= S_INJ;
                        else begin
                            for (int i = 0; i < 16; i++) r_chain[i] <= mixed[i] ^ r_msg[i];
                            r_state <= r_emit ? S_OUT : S_IDLE;
                        end
                    end else if (r_rnd[1:0] == 2'd3) r_state <= S_INJ;
                end
                S_OUT: if (!i_stall) begin
                    r_oidx <= r_oidx + 4'd1;
                    if (r_oidx == 4'd15) begin
                        r_state <= S_IDLE;
                        if (r_keep) r_chain <= r_old;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_INJ && r_rnd == 7'(ROUNDS)) r_tflg[62] <= 1'b0;
            if (r_state == S_RUN && r_rnd == 7'(ROUNDS - 1) && (ROUNDS % 4 != 0))
                r_tflg[62] <= 1'b0;
        end
    end

    `SKA_ASSERT_IMP(a_out_only_out, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `SKA_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, o_req_stall)
    `SKA_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_valid && o_last_out && !i_stall,
        r_state == S_IDLE)
endmodule

/* hw/rtl/skein1024_ubi_block_engine_top.sv */
// Top level of the Skein-1024 UBI block engine.
// channel | dir | handshake            | payload
// in      | in  | i_valid / o_stall    | data_word, byte_count, flags
// out     | out | o_valid / i_stall    | chain_word, last_out
// Each word is taken while o_stall is low; the sixteenth starts a block request.
// A block runs in the single round unit, then gives 16 output words if emit or keep is set.
// The front collects the next block while the back runs; one block waits at most.
// Reset (synchronous, active low) zeroes chain, tweak and word count.
// Output words hold while i_stall is high.
module skein1024_ubi_block_engine_top #(
    parameter int ROUNDS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [7:0]  i_byte_count,
    input  logic        i_new_type,
    input  logic [5:0]  i_block_type,
    input  logic        i_final_block,
    input  logic        i_clear_chain,
    input  logic        i_emit_chain,
    input  logic        i_keep_chain,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_chain_word,
    output logic        o_last_out
);
    logic req_valid, req_stall;
    sk1024_pkg::t_blk_req req;

    sk1024_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data_word, .i_byte_count,
        .i_new_type, .i_block_type, .i_final_block, .i_clear_chain,
        .i_emit_chain, .i_keep_chain,
        .o_req_valid(req_valid), .i_req_stall(req_stall), .o_req(req)
    );

    sk1024_back #(.ROUNDS(ROUNDS)) u_back (
        .i_clk, .i_rst_n, .i_req_valid(req_valid), .o_req_stall(req_stall),
        .i_req(req), .o_valid, .i_stall, .o_chain_word, .o_last_out
    );
endmodule
